// ===== design/dwfrt_pkg.sv =====
`timescale 1ns / 1ps
// dwfrt_pkg: shared types and constants for the dual window fault rate trip unit.
// No dependencies.
package dwfrt_pkg;

    // opcode codes on the slave side tuser
    localparam logic [1:0] OP_FAULT = 2'd0;
    localparam logic [1:0] OP_STOP  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // trip cause codes
    localparam logic [1:0] CAUSE_NONE   = 2'd0;
    localparam logic [1:0] CAUSE_NARROW = 2'd1;
    localparam logic [1:0] CAUSE_WIDE   = 2'd2;
    localparam logic [1:0] CAUSE_STOP   = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_NARROW_MS  = 2'd0;
    localparam logic [1:0] REG_NARROW_LIM = 2'd1;
    localparam logic [1:0] REG_WIDE_MS    = 2'd2;
    localparam logic [1:0] REG_WIDE_LIM   = 2'd3;

    // reset values
    localparam logic [15:0] RST_NARROW_MS  = 16'd3000;
    localparam logic [2:0]  RST_NARROW_LIM = 3'd2;
    localparam logic [15:0] RST_WIDE_MS    = 16'd6000;
    localparam logic [2:0]  RST_WIDE_LIM   = 3'd3;

    localparam int TIME_W  = 32;
    localparam int WIN_W   = 16;
    localparam int LIM_W   = 3;
    localparam int OCNT_W  = 4;
    localparam int ODATA_W = 16;

    typedef logic [TIME_W-1:0] t_time;

    // result item, highest bits first when packed onto tdata; fail_safe_on is bit 0
    typedef struct packed {
        logic [ODATA_W-13:0] pad;
        logic                ignored;
        logic [OCNT_W-1:0]   wide_count;
        logic [OCNT_W-1:0]   narrow_count;
        logic [1:0]          trip_cause;
        logic                fail_safe_on;
    } t_result;

endpackage

// ===== design/dual_window_fault_rate_trip_unit.sv =====
`timescale 1ns / 1ps
// dual_window_fault_rate_trip_unit: top level, sequencer, latch and config registers.
// Depends on dwfrt_pkg and dwfrt_ram.

// Fault-rate monitor with a latched fail-safe. Each transfer on the slave side is one
// item: tuser carries the opcode (fault, emergency stop, clear) and tdata the 32-bit
// millisecond timestamp. A fault taken while the latch is clear is stored in a ring of
// FAULT_DEPTH timestamps; entries older than the wide window are dropped from the
// oldest end, then every remaining entry is aged against the narrow window, and the
// latch trips if the narrow count (checked first) or the wide count reaches its limit.
// An emergency stop trips the latch at once, a clear releases it and keeps the ring.
// Timing: s_axis_tready is high only while the sequencer is idle. A stop, a clear or
// an ignored fault goes from the transfer straight to the done state and back to idle.
// An accepted fault writes the ring, drops old entries, counts the rest, evaluates the
// limits and finishes; the cost grows with the entries dropped and left and is set by
// a single subtract-and-compare unit that walks the ring one RAM read at a time (read
// address in one state, data and compare in the state after). Either path waits in the
// done state while the output register still holds an earlier result. A finished result
// sits in the output register, so the next item can be taken while it waits for
// m_axis_tready. Configuration writes are always taken (o_cfg_ready is tied high) and
// should only happen while the block is idle. The timestamp RAM is not cleared after
// reset; only entries that have been written are ever read.
module dual_window_fault_rate_trip_unit #(
    parameter int FAULT_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] time_ms
    input  logic [1:0]  s_axis_tuser,   // [1:0] opcode
    // result output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [0] fail_safe_on, [2:1] trip_cause,
                                        // [6:3] narrow_count, [10:7] wide_count,
                                        // [11] ignored, [15:12] zero
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int IDX_W = $clog2(FAULT_DEPTH);
    localparam int CNT_W = $clog2(FAULT_DEPTH + 1);
    localparam int CMP_W = (CNT_W > dwfrt_pkg::LIM_W) ? CNT_W : dwfrt_pkg::LIM_W;
    localparam int SAT_W = (CNT_W > dwfrt_pkg::OCNT_W) ? CNT_W : dwfrt_pkg::OCNT_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_WRITE     = 3'd1;
    localparam logic [2:0] ST_PRUNE_RD  = 3'd2;
    localparam logic [2:0] ST_PRUNE_CHK = 3'd3;
    localparam logic [2:0] ST_CNT_RD    = 3'd4;
    localparam logic [2:0] ST_CNT_CHK   = 3'd5;
    localparam logic [2:0] ST_EVAL      = 3'd6;
    localparam logic [2:0] ST_DONE      = 3'd7;

    function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] p);
        slot_inc = (p == IDX_W'(FAULT_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [dwfrt_pkg::OCNT_W-1:0] sat15(input logic [CNT_W-1:0] v);
        logic [SAT_W-1:0] ext;
        ext   = SAT_W'(v);
        sat15 = (ext > SAT_W'(15)) ? '1 : ext[dwfrt_pkg::OCNT_W-1:0];
    endfunction

    // config registers
    logic [dwfrt_pkg::WIN_W-1:0] r_narrow_ms, r_wide_ms;
    logic [dwfrt_pkg::LIM_W-1:0] r_narrow_lim, r_wide_lim;

    // control state
    logic [2:0]       r_state,  n_state;
    logic [IDX_W-1:0] r_oldest, n_oldest;
    logic [CNT_W-1:0] r_count,  n_count;
    logic [IDX_W-1:0] r_ptr,    n_ptr;
    logic [CNT_W-1:0] r_k,      n_k;
    logic [CNT_W-1:0] r_narrow, n_narrow;
    logic [CNT_W-1:0] r_wide,   n_wide;
    logic             r_latch,  n_latch;
    logic [1:0]       r_cause,  n_cause;
    logic             r_ignored, n_ignored;
    logic             r_out_valid, n_out_valid;

    // payload
    dwfrt_pkg::t_time   r_now, n_now;
    dwfrt_pkg::t_result r_out, n_out;

    // RAM ports
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr, ram_raddr;
    dwfrt_pkg::t_time  ram_rdata;

    // shared age unit
    dwfrt_pkg::t_time            age;
    logic [dwfrt_pkg::WIN_W-1:0] win_sel;
    logic                        age_over;

    logic              in_xfer, full;
    logic [IDX_W:0]    tail_sum;
    logic [IDX_W-1:0]  tail_slot;
    logic [CMP_W-1:0]  narrow_ext, wide_ext;

    dwfrt_ram #(
        .WIDTH(dwfrt_pkg::TIME_W),
        .DEPTH(FAULT_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_now),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

    // one subtractor, one comparator; window chosen by phase
    assign win_sel  = (r_state == ST_PRUNE_CHK) ? r_wide_ms : r_narrow_ms;
    assign age      = r_now - ram_rdata;
    assign age_over = (age > dwfrt_pkg::TIME_W'(win_sel));

    assign full      = (r_count == CNT_W'(FAULT_DEPTH));
    assign tail_sum  = {1'b0, r_oldest} + {1'b0, r_count[IDX_W-1:0]};
    assign tail_slot = (tail_sum >= (IDX_W + 1)'(FAULT_DEPTH)) ?
                       IDX_W'(tail_sum - (IDX_W + 1)'(FAULT_DEPTH)) : tail_sum[IDX_W-1:0];

    assign narrow_ext = CMP_W'(r_narrow);
    assign wide_ext   = CMP_W'(r_count);

    assign ram_we    = (r_state == ST_WRITE);
    assign ram_waddr = full ? r_oldest : tail_slot;
    assign ram_raddr = (r_state == ST_CNT_RD) ? r_ptr : r_oldest;

    always_comb begin
        n_state     = r_state;
        n_oldest    = r_oldest;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_k         = r_k;
        n_narrow    = r_narrow;
        n_wide      = r_wide;
        n_latch     = r_latch;
        n_cause     = r_cause;
        n_ignored   = r_ignored;
        n_now       = r_now;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        if (r_out_valid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_now     = s_axis_tdata;
                    n_cause   = dwfrt_pkg::CAUSE_NONE;
                    n_ignored = 1'b0;
                    n_narrow  = '0;
                    n_wide    = '0;
                    n_state   = ST_DONE;
                    case (s_axis_tuser)
                        dwfrt_pkg::OP_FAULT: begin
                            if (r_latch) begin
                                n_ignored = 1'b1;
                            end else begin
                                n_state = ST_WRITE;
                            end
                        end
                        dwfrt_pkg::OP_STOP: begin
                            if (r_latch) begin
                                n_ignored = 1'b1;
                            end else begin
                                n_latch = 1'b1;
                                n_cause = dwfrt_pkg::CAUSE_STOP;
                            end
                        end
                        dwfrt_pkg::OP_CLEAR: begin
                            if (r_latch) begin
                                n_latch = 1'b0;
                            end else begin
                                n_ignored = 1'b1;
                            end
                        end
                        default: begin
                            n_ignored = 1'b1;
                        end
                    endcase
                end
            end
            ST_WRITE: begin
                // ring full: overwrite oldest
                if (full) begin
                    n_oldest = slot_inc(r_oldest);
                end else begin
                    n_count = r_count + 1'b1;
                end
                n_state = ST_PRUNE_RD;
            end
            ST_PRUNE_RD: begin
                n_state = ST_PRUNE_CHK;
            end
            ST_PRUNE_CHK: begin
                if (r_count != '0 && age_over) begin
                    n_oldest = slot_inc(r_oldest);
                    n_count  = r_count - 1'b1;
                    n_state  = ST_PRUNE_RD;
                end else begin
                    n_ptr   = r_oldest;
                    n_k     = '0;
                    n_state = (r_count == '0) ? ST_EVAL : ST_CNT_RD;
                end
            end
            ST_CNT_RD: begin
                n_state = ST_CNT_CHK;
            end
            ST_CNT_CHK: begin
                if (!age_over) begin
                    n_narrow = r_narrow + 1'b1;
                end
                n_ptr   = slot_inc(r_ptr);
                n_k     = r_k + 1'b1;
                n_state = ((r_k + 1'b1) == r_count) ? ST_EVAL : ST_CNT_RD;
            end
            ST_EVAL: begin
                n_wide = r_count;
                if (narrow_ext >= CMP_W'(r_narrow_lim)) begin
                    n_latch = 1'b1;
                    n_cause = dwfrt_pkg::CAUSE_NARROW;
                end else if (wide_ext >= CMP_W'(r_wide_lim)) begin
                    n_latch = 1'b1;
                    n_cause = dwfrt_pkg::CAUSE_WIDE;
                end
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out.pad          = '0;
                    n_out.fail_safe_on = r_latch;
                    n_out.trip_cause   = r_cause;
                    n_out.narrow_count = sat15(r_narrow);
                    n_out.wide_count   = sat15(r_wide);
                    n_out.ignored      = r_ignored;
                    n_out_valid        = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_oldest    <= '0;
            r_count     <= '0;
            r_ptr       <= '0;
            r_k         <= '0;
            r_narrow    <= '0;
            r_wide      <= '0;
            r_latch     <= 1'b0;
            r_cause     <= dwfrt_pkg::CAUSE_NONE;
            r_ignored   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_oldest    <= n_oldest;
            r_count     <= n_count;
            r_ptr       <= n_ptr;
            r_k         <= n_k;
            r_narrow    <= n_narrow;
            r_wide      <= n_wide;
            r_latch     <= n_latch;
            r_cause     <= n_cause;
            r_ignored   <= n_ignored;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now <= n_now;
        r_out <= n_out;
    end

    // config registers; writes taken every cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_narrow_ms  <= dwfrt_pkg::RST_NARROW_MS;
            r_narrow_lim <= dwfrt_pkg::RST_NARROW_LIM;
            r_wide_ms    <= dwfrt_pkg::RST_WIDE_MS;
            r_wide_lim   <= dwfrt_pkg::RST_WIDE_LIM;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                dwfrt_pkg::REG_NARROW_MS:  r_narrow_ms  <= i_cfg_data;
                dwfrt_pkg::REG_NARROW_LIM: r_narrow_lim <= i_cfg_data[dwfrt_pkg::LIM_W-1:0];
                dwfrt_pkg::REG_WIDE_MS:    r_wide_ms    <= i_cfg_data;
                dwfrt_pkg::REG_WIDE_LIM:   r_wide_lim   <= i_cfg_data[dwfrt_pkg::LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // ring occupancy never exceeds its depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FAULT_DEPTH))
        else $error("ring occupancy above depth");

    // a result reporting a trip must show the latch set
    a_trip_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.trip_cause != dwfrt_pkg::CAUSE_NONE) |-> r_out.fail_safe_on)
        else $error("trip reported with latch clear");

    // a fault taken with the latch clear starts the ring write
    a_fault_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && s_axis_tuser == dwfrt_pkg::OP_FAULT && !r_latch) |=> (r_state == ST_WRITE))
        else $error("accepted fault did not reach ring write");

endmodule

// ===== design/dwfrt_ram.sv =====
`timescale 1ns / 1ps
// dwfrt_ram: generic single write, single read RAM with registered read data.
// No dependencies.
module dwfrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sim/dual_window_fault_rate_trip_unit_test.sv =====
`timescale 1ns / 1ps
// dual_window_fault_rate_trip_unit_test: self-checking bench for the fault-rate trip unit.
// Depends on dwfrt_pkg and the design sources; predicts every result internally.

module dual_window_fault_rate_trip_unit_test;
    import dwfrt_pkg::*;

    // Ring depth used both for the instance and for the internal prediction.
    localparam int RING_DEPTH = 8;
    // Settling wait, well beyond the longest walk an accepted fault makes through the ring.
    localparam int SETTLE_CYCLES = 4 * RING_DEPTH + 16;
    // Opcode 3 has no meaning in the block and must come back ignored.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Hard stop for the whole run, in nanoseconds, with a 2 ns clock period.
    localparam int RUN_LIMIT_NS = 2_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;     // [31:0] time_ms
    logic [1:0]  s_axis_tuser = OP_FAULT; // [1:0] opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [0] fail_safe_on, [2:1] trip_cause,
                                        // [6:3] narrow_count, [10:7] wide_count,
                                        // [11] ignored, [15:12] zero
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = REG_NARROW_MS;
    logic [15:0] i_cfg_data = '0;

    // Idling percentages for the sender and the receiver, changed between phases.
    int unsigned send_gap_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned error_count = 0;

    // Results still owed by the block, oldest first.
    t_result pending_results[$];

    // Own copy of the block's configuration, at its reset values.
    logic [15:0] narrow_ms  = RST_NARROW_MS;
    logic [2:0]  narrow_lim = RST_NARROW_LIM;
    logic [15:0] wide_ms    = RST_WIDE_MS;
    logic [2:0]  wide_lim   = RST_WIDE_LIM;

    // Own copy of the timestamp ring and the latch.
    t_time ring_time [RING_DEPTH];
    int    ring_head = 0;
    int    ring_fill = 0;
    logic  trip_latched = 1'b0;

    // Running millisecond clock for the random traffic.
    t_time clock_ms = 32'd200000;

    dual_window_fault_rate_trip_unit #(
        .FAULT_DEPTH(RING_DEPTH)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Receiver back-pressure, redrawn every cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Works out the result of one item and advances the ring and latch copy.
    function automatic t_result predict_trip_result(input logic [1:0] op, input t_time now_ms);
        t_result r;
        t_time   age;
        int      narrow_hits;
        r = '0;
        narrow_hits = 0;
        case (op)
            OP_FAULT: begin
                if (trip_latched) begin
                    r.ignored = 1'b1;
                end else begin
                    // full ring: the new stamp replaces the oldest one
                    if (ring_fill == RING_DEPTH) begin
                        ring_time[ring_head] = now_ms;
                        ring_head = (ring_head + 1) % RING_DEPTH;
                    end else begin
                        ring_time[(ring_head + ring_fill) % RING_DEPTH] = now_ms;
                        ring_fill++;
                    end
                    // drop from the old end while older than the wide window
                    while (ring_fill > 0 &&
                           t_time'(now_ms - ring_time[ring_head]) > wide_ms) begin
                        ring_head = (ring_head + 1) % RING_DEPTH;
                        ring_fill--;
                    end
                    for (int k = 0; k < ring_fill; k++) begin
                        age = now_ms - ring_time[(ring_head + k) % RING_DEPTH];
                        if (age <= narrow_ms) narrow_hits++;
                    end
                    r.narrow_count = (narrow_hits > 15) ? 4'd15 : 4'(narrow_hits);
                    r.wide_count   = (ring_fill > 15) ? 4'd15 : 4'(ring_fill);
                    // narrow window has priority
                    if (narrow_hits >= narrow_lim) begin
                        trip_latched = 1'b1;
                        r.trip_cause = CAUSE_NARROW;
                    end else if (ring_fill >= wide_lim) begin
                        trip_latched = 1'b1;
                        r.trip_cause = CAUSE_WIDE;
                    end
                end
            end
            OP_STOP: begin
                if (trip_latched) begin
                    r.ignored = 1'b1;
                end else begin
                    trip_latched = 1'b1;
                    r.trip_cause = CAUSE_STOP;
                end
            end
            OP_CLEAR: begin
                if (trip_latched) trip_latched = 1'b0;
                else r.ignored = 1'b1;
            end
            default: begin
                r.ignored = 1'b1;
            end
        endcase
        r.fail_safe_on = trip_latched;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] wanted);
        $display("MISMATCH at %0t: %s got %0h wanted %0h", $realtime, what, got, wanted);
        error_count++;
    endtask

    // Result checker: every output transfer is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = t_result'(m_axis_tdata);
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", m_axis_tdata, '0);
            end else begin
                want = pending_results.pop_front();
                if (seen.fail_safe_on !== want.fail_safe_on)
                    report_mismatch("fail_safe_on", seen.fail_safe_on, want.fail_safe_on);
                if (seen.trip_cause !== want.trip_cause)
                    report_mismatch("trip_cause", seen.trip_cause, want.trip_cause);
                if (seen.narrow_count !== want.narrow_count)
                    report_mismatch("narrow_count", seen.narrow_count, want.narrow_count);
                if (seen.wide_count !== want.wide_count)
                    report_mismatch("wide_count", seen.wide_count, want.wide_count);
                if (seen.ignored !== want.ignored)
                    report_mismatch("ignored", seen.ignored, want.ignored);
                if (seen.pad !== want.pad)
                    report_mismatch("padding bits", seen.pad, want.pad);
            end
        end
    end

    // One item on the slave side. tvalid is left high after the transfer so that
    // back-to-back items never lower and raise it in the same step; a gap lowers it.
    task automatic send_item(input logic [1:0] op, input t_time stamp, output logic skipped);
        t_result want;
        if ($urandom_range(99) < send_gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= stamp;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        want = predict_trip_result(op, stamp);
        pending_results.push_back(want);
        skipped = want.ignored;
    endtask

    // Let every owed result drain, then give the sequencer time to fall idle.
    task automatic wait_until_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // One register transfer; cfg valid stays high for the next write.
    task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (index)
            REG_NARROW_MS:  narrow_ms  = data;
            REG_NARROW_LIM: narrow_lim = data[2:0];
            REG_WIDE_MS:    wide_ms    = data;
            REG_WIDE_LIM:   wide_lim   = data[2:0];
            default: ;
        endcase
    endtask

    // Writes all four registers while idle; upper bits of the limit writes carry noise.
    task automatic configure(input logic [15:0] nms, input logic [2:0] nlim,
                             input logic [15:0] wms, input logic [2:0] wlim);
        logic [15:0] noise;
        wait_until_idle();
        noise = 16'($urandom());
        write_reg(REG_NARROW_MS, nms);
        write_reg(REG_NARROW_LIM, {noise[15:3], nlim});
        write_reg(REG_WIDE_MS, wms);
        noise = 16'($urandom());
        write_reg(REG_WIDE_LIM, {noise[15:3], wlim});
        i_cfg_valid <= 1'b0;
    endtask

    // Time step for the next item, scaled to the current windows.
    function automatic t_time next_gap_ms();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 4) return t_time'($urandom());
        if (pick < 12) begin
            // exactly on a window edge, or just past it
            case ($urandom_range(3))
                0: return narrow_ms;
                1: return narrow_ms + 1;
                2: return wide_ms;
                default: return wide_ms + 1;
            endcase
        end
        if (pick < 50) return $urandom_range(narrow_ms / 2 + 1);
        if (pick < 88) return $urandom_range(wide_ms + 1);
        return wide_ms + $urandom_range(wide_ms + 2);
    endfunction

    // Mostly faults while clear and clears while tripped, so the ring keeps filling;
    // the rest is stops, stray clears, faults into a set latch and opcode 3.
    task automatic run_traffic(input int unsigned wanted);
        int unsigned done_items;
        int unsigned pick;
        logic [1:0]  op;
        logic        skipped;
        done_items = 0;
        while (done_items < wanted) begin
            pick = $urandom_range(99);
            if (trip_latched)
                op = (pick < 70) ? OP_CLEAR : (pick < 85) ? OP_FAULT :
                     (pick < 95) ? OP_STOP : OP_UNUSED;
            else
                op = (pick < 85) ? OP_FAULT : (pick < 91) ? OP_STOP :
                     (pick < 96) ? OP_CLEAR : OP_UNUSED;
            clock_ms = clock_ms + next_gap_ms();
            send_item(op, clock_ms, skipped);
            done_items++;
        end
    endtask

    // Latch behaviour at the reset configuration: unused opcode, clear while clear,
    // ageing out of both windows, narrow trip, items into a set latch, stop, and a
    // narrow burst across the 2^32 wrap.
    task automatic test_latch_ops();
        logic skipped;
        send_item(OP_UNUSED, 32'd0, skipped);
        send_item(OP_CLEAR, 32'd0, skipped);
        send_item(OP_FAULT, 32'd0, skipped);
        send_item(OP_FAULT, 32'd3001, skipped);
        send_item(OP_FAULT, 32'd6002, skipped);
        send_item(OP_FAULT, 32'd9003, skipped);
        send_item(OP_FAULT, 32'd12003, skipped);   // second fault at exactly the narrow age
        send_item(OP_FAULT, 32'd12004, skipped);
        send_item(OP_STOP, 32'd12005, skipped);
        send_item(OP_UNUSED, 32'd12006, skipped);
        send_item(OP_CLEAR, 32'd12007, skipped);
        send_item(OP_STOP, 32'd12008, skipped);
        send_item(OP_CLEAR, 32'd12009, skipped);
        send_item(OP_FAULT, 32'hFFFF_FFFF, skipped);
        send_item(OP_FAULT, 32'd1000, skipped);
        send_item(OP_CLEAR, 32'd1001, skipped);
    endtask

    // Fill the ring, trip on the wide count, keep clearing so the ring wraps and
    // overwrites, then age everything out, with one entry exactly at the wide age.
    task automatic test_ring_full();
        logic skipped;
        configure(16'd2, 3'd7, 16'hFFFF, 3'd7);
        for (int k = 1; k <= 7; k++) send_item(OP_FAULT, t_time'(100 * k), skipped);
        send_item(OP_CLEAR, 32'd750, skipped);
        send_item(OP_FAULT, 32'd800, skipped);
        send_item(OP_CLEAR, 32'd850, skipped);
        send_item(OP_FAULT, 32'd900, skipped);
        send_item(OP_CLEAR, 32'd950, skipped);
        send_item(OP_FAULT, 32'd66436, skipped);
        send_item(OP_FAULT, 32'd131971, skipped);
    endtask

    task automatic test_burst_trips();
        configure(16'd500, 3'd3, 16'd4000, 3'd6);
        run_traffic(185);
    endtask

    task automatic test_wide_spread();
        configure(16'd200, 3'd7, 16'd5000, 3'd4);
        run_traffic(185);
    endtask

    task automatic test_window_extremes();
        configure(16'hFFFF, 3'd7, 16'hFFFF, 3'd7);
        run_traffic(95);
        configure(16'd1, 3'd2, 16'd1, 3'd7);
        run_traffic(95);
    endtask

    // Wide window shorter than the narrow one: pruning decides both counts.
    task automatic test_wide_below_narrow();
        configure(16'd4000, 3'd4, 16'd1500, 3'd3);
        run_traffic(180);
    endtask

    // Zero limits trip every accepted fault; zero-length windows keep only the newest.
    task automatic test_zero_limits();
        configure(16'd0, 3'd0, 16'd0, 3'd7);
        run_traffic(92);
        configure(16'd100, 3'd7, 16'd0, 3'd0);
        run_traffic(92);
    endtask

    task automatic test_random_config();
        for (int k = 0; k < 4; k++) begin
            configure(16'($urandom()), 3'($urandom()), 16'($urandom()), 3'($urandom()));
            run_traffic(46);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // sender mostly busy, receiver mostly stalled
        send_gap_pct   = 7;
        recv_stall_pct = 87;
        test_latch_ops();
        test_ring_full();
        test_burst_trips();
        test_wide_spread();

        // sender mostly idle, receiver mostly ready
        send_gap_pct   = 87;
        recv_stall_pct = 7;
        test_window_extremes();
        test_wide_below_narrow();

        // full rate both ways
        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_zero_limits();
        test_random_config();

        wait_until_idle();
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/dwfrt_pkg.sv
design/dwfrt_ram.sv
design/dual_window_fault_rate_trip_unit.sv
sim/dual_window_fault_rate_trip_unit_test.sv
